// ===== design/cci_pkg.sv =====
// Shared types and constants for the commodity channel index block.
package cci_pkg;

    localparam int PRICE_W  = 32;
    localparam int PERIOD_W = 7;
    localparam int CCI_W    = 24;
    localparam int SUM3_W   = PRICE_W + 2;
    localparam int TCNT_W   = 2;
    localparam int RECIP_W  = 34;
    localparam int TP_SHIFT = 35;
    localparam logic [TCNT_W-1:0] TP_STEPS = 2'd2;
    // ceil(2^35 / 3); exact floor divide by three for sums below 2^35
    localparam logic [RECIP_W-1:0] RECIP3 = 34'h2_AAAA_AAAB;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 7'd20;
    localparam logic [2:0] REG_PERIOD_ADDR = 3'd0;
    localparam logic [CCI_W-1:0] CCI_MAX = 24'h7FFFFF;
    localparam logic [CCI_W-1:0] CCI_MIN = 24'h800000;

    typedef enum logic [3:0] {
        ST_IDLE, ST_TP_DIV, ST_WRITE, ST_RD1, ST_ACC1, ST_RD2, ST_MUL2, ST_ACC2,
        ST_PROD_TP, ST_MAG, ST_NUMW, ST_NUM, ST_QDIV, ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_TP_STEP, OP_WRITE, OP_RD, OP_ACC1, OP_MUL2, OP_ACC2,
        OP_PROD_TP, OP_MAG, OP_NUMW, OP_NUM, OP_Q_STEP, OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic tp_done;
        logic last_entry;
        logic q_done;
        logic out_free;
    } sts_t;

endpackage

// ===== design/commodity_channel_index.sv =====
// Commodity channel index: one price bar per word in, one index word out.
//
// s_ channel: one bar per word (high, low, close in Q16.16); tuser carries
// the start flag, which restarts the series before the bar is stored.
// m_ channel: signed Q15.8 index with flat and saturated flags in tuser.
// APB port: window_period at byte address 0, 1..64 bars, 0 taken as 1,
// values above MAX_PERIOD taken as MAX_PERIOD.
// Steps from input accept to result valid, with w the window length:
// divide by three, ring write, sum pass over w entries, deviation pass
// over w entries, product, magnitude, numerator and divisor setup,
// bit-serial quotient, output load.
// One bar is in work at a time; the next is taken in the idle cycle after
// the result is loaded.
// The two window passes through the single ring memory port and the
// one-bit-a-cycle quotient set the rate at which bars are taken.
// The result sits in an output register; when the receiver stalls, the next
// bar is still taken and worked, and waits at the end until the register
// frees. Reset clears the history counts and sets the period to 20; the
// ring contents need no clearing since only written entries are read.
module commodity_channel_index #(
    parameter int MAX_PERIOD = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // high_price, low_price, close_price
    input  logic [0:0]  s_tuser,   // start_series
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // cci_value
    output logic [1:0]  m_tuser,   // flat_window, saturated
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [cci_pkg::PERIOD_W-1:0] period_reg;
    cci_pkg::cmd_t cmd;
    cci_pkg::sts_t sts;
    logic flat_w, sat_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            period_reg <= cci_pkg::PERIOD_RESET;
        end else if (psel && penable && pwrite && paddr == cci_pkg::REG_PERIOD_ADDR) begin
            period_reg <= pwdata[cci_pkg::PERIOD_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == cci_pkg::REG_PERIOD_ADDR) ? 32'(period_reg) : '0;

    cci_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .sts      (sts),
        .in_ready (s_tready),
        .cmd      (cmd)
    );

    cci_datapath #(
        .MAX_PERIOD (MAX_PERIOD)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .high_price    (s_tdata[31:0]),
        .low_price     (s_tdata[63:32]),
        .close_price   (s_tdata[95:64]),
        .start_series  (s_tuser[0]),
        .window_period (period_reg),
        .out_ready     (m_tready),
        .sts           (sts),
        .out_valid     (m_tvalid),
        .cci_value     (m_tdata),
        .flat_window   (flat_w),
        .saturated     (sat_w)
    );

    assign m_tuser = {sat_w, flat_w};

endmodule

// ===== design/cci_ctrl.sv =====
// Controller state machine sequencing the index datapath.
module cci_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    input  cci_pkg::sts_t sts,
    output logic          in_ready,
    output cci_pkg::cmd_t cmd
);

    cci_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cci_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            cci_pkg::ST_IDLE:    if (in_valid) state_next = cci_pkg::ST_TP_DIV;
            cci_pkg::ST_TP_DIV:  if (sts.tp_done) state_next = cci_pkg::ST_WRITE;
            cci_pkg::ST_WRITE:   state_next = cci_pkg::ST_RD1;
            cci_pkg::ST_RD1:     state_next = cci_pkg::ST_ACC1;
            cci_pkg::ST_ACC1:    state_next = sts.last_entry ? cci_pkg::ST_RD2
                                                             : cci_pkg::ST_RD1;
            cci_pkg::ST_RD2:     state_next = cci_pkg::ST_MUL2;
            cci_pkg::ST_MUL2:    state_next = cci_pkg::ST_ACC2;
            cci_pkg::ST_ACC2:    state_next = sts.last_entry ? cci_pkg::ST_PROD_TP
                                                             : cci_pkg::ST_RD2;
            cci_pkg::ST_PROD_TP: state_next = cci_pkg::ST_MAG;
            cci_pkg::ST_MAG:     state_next = cci_pkg::ST_NUMW;
            cci_pkg::ST_NUMW:    state_next = cci_pkg::ST_NUM;
            cci_pkg::ST_NUM:     state_next = cci_pkg::ST_QDIV;
            cci_pkg::ST_QDIV:    if (sts.q_done) state_next = cci_pkg::ST_DONE;
            cci_pkg::ST_DONE:    if (sts.out_free) state_next = cci_pkg::ST_IDLE;
            default:             state_next = cci_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        cmd.op   = cci_pkg::OP_NONE;
        unique case (state_reg)
            cci_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = cci_pkg::OP_LOAD;
            end
            cci_pkg::ST_TP_DIV:  if (!sts.tp_done) cmd.op = cci_pkg::OP_TP_STEP;
            cci_pkg::ST_WRITE:   cmd.op = cci_pkg::OP_WRITE;
            cci_pkg::ST_RD1:     cmd.op = cci_pkg::OP_RD;
            cci_pkg::ST_ACC1:    cmd.op = cci_pkg::OP_ACC1;
            cci_pkg::ST_RD2:     cmd.op = cci_pkg::OP_RD;
            cci_pkg::ST_MUL2:    cmd.op = cci_pkg::OP_MUL2;
            cci_pkg::ST_ACC2:    cmd.op = cci_pkg::OP_ACC2;
            cci_pkg::ST_PROD_TP: cmd.op = cci_pkg::OP_PROD_TP;
            cci_pkg::ST_MAG:     cmd.op = cci_pkg::OP_MAG;
            cci_pkg::ST_NUMW:    cmd.op = cci_pkg::OP_NUMW;
            cci_pkg::ST_NUM:     cmd.op = cci_pkg::OP_NUM;
            cci_pkg::ST_QDIV:    if (!sts.q_done) cmd.op = cci_pkg::OP_Q_STEP;
            cci_pkg::ST_DONE:    if (sts.out_free) cmd.op = cci_pkg::OP_OUT;
            default:             cmd.op = cci_pkg::OP_NONE;
        endcase
    end

endmodule

// ===== design/cci_datapath.sv =====
// Datapath: typical price, ring memory, window sums and serial quotient.
module cci_datapath #(
    parameter int MAX_PERIOD = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  cci_pkg::cmd_t                cmd,
    input  logic [cci_pkg::PRICE_W-1:0]  high_price,
    input  logic [cci_pkg::PRICE_W-1:0]  low_price,
    input  logic [cci_pkg::PRICE_W-1:0]  close_price,
    input  logic                         start_series,
    input  logic [cci_pkg::PERIOD_W-1:0] window_period,
    input  logic                         out_ready,
    output cci_pkg::sts_t                sts,
    output logic                         out_valid,
    output logic [cci_pkg::CCI_W-1:0]    cci_value,
    output logic                         flat_window,
    output logic                         saturated
);

    localparam int AW   = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;
    localparam int WB   = $clog2(MAX_PERIOD + 1);
    localparam int SW   = cci_pkg::PRICE_W + WB;
    localparam int DW   = SW + WB;
    localparam int NW   = DW + 16;
    localparam int RW   = DW + 3;
    localparam int QCW  = $clog2(NW + 1);
    localparam int HALF = cci_pkg::SUM3_W / 2;
    localparam int TPROD_W = HALF + cci_pkg::RECIP_W;
    localparam int TACC_W  = cci_pkg::SUM3_W + cci_pkg::RECIP_W;
    localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_PERIOD - 1);

    logic [cci_pkg::PRICE_W-1:0] ring_mem [MAX_PERIOD];
    logic [cci_pkg::PRICE_W-1:0] rdata_reg;

    logic [cci_pkg::SUM3_W-1:0] tpq_reg;
    logic [TACC_W-1:0]          tacc_reg;
    logic [cci_pkg::TCNT_W-1:0] tcnt_reg;
    logic [AW-1:0] slot_reg, cur_reg, addr_reg;
    logic [WB-1:0] seen_reg, w_reg, k_reg;
    logic [SW-1:0] sum_reg, prod_reg, mag_reg;
    logic [DW-1:0] dev_reg, nw_reg;
    logic          neg_reg;
    logic [NW-1:0] qsh_reg;
    logic [RW-1:0] qrem_reg, den_reg;
    logic [QCW-1:0] qcnt_reg;
    logic          out_valid_reg;
    logic [cci_pkg::CCI_W-1:0] cci_reg;
    logic          flat_reg, sat_reg;

    logic [HALF-1:0]    t_half;
    logic [TPROD_W-1:0] t_prod;
    logic [cci_pkg::PRICE_W-1:0] tp_val;
    logic [WB-1:0] seen_new, p_clamp;
    logic [SW-1:0] absdiff;
    logic [NW-1:0] num_base;
    logic [RW-1:0] q_trial;
    logic [AW-1:0] addr_dec;

    // divide by three as a reciprocal multiply, one 17-bit half per cycle
    assign t_half   = (tcnt_reg == '0) ? tpq_reg[HALF-1:0]
                                       : tpq_reg[cci_pkg::SUM3_W-1:HALF];
    assign t_prod   = TPROD_W'(t_half) * TPROD_W'(cci_pkg::RECIP3);
    assign tp_val   = tacc_reg[cci_pkg::TP_SHIFT+cci_pkg::PRICE_W-1:cci_pkg::TP_SHIFT];
    assign seen_new = (32'(seen_reg) < MAX_PERIOD) ? seen_reg + 1'b1 : seen_reg;
    assign absdiff  = (prod_reg >= sum_reg) ? prod_reg - sum_reg : sum_reg - prod_reg;
    assign num_base = NW'(nw_reg);
    assign q_trial  = {qrem_reg[RW-2:0], qsh_reg[NW-1]};
    assign addr_dec = (addr_reg == '0) ? SLOT_LAST : addr_reg - 1'b1;

    always_comb begin
        if (window_period == '0) begin
            p_clamp = WB'(1);
        end else if (32'(window_period) > MAX_PERIOD) begin
            p_clamp = WB'(MAX_PERIOD);
        end else begin
            p_clamp = WB'(window_period);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == cci_pkg::OP_WRITE) ring_mem[slot_reg] <= tp_val;
        if (cmd.op == cci_pkg::OP_RD) rdata_reg <= ring_mem[addr_reg];
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            tcnt_reg      <= '0;
            qcnt_reg      <= '0;
            k_reg         <= '0;
        end else begin
            if (cmd.op == cci_pkg::OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && out_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                cci_pkg::OP_LOAD: begin
                    tcnt_reg <= '0;
                    if (start_series) begin
                        slot_reg <= '0;
                        seen_reg <= '0;
                    end
                end
                cci_pkg::OP_TP_STEP: tcnt_reg <= tcnt_reg + 1'b1;
                cci_pkg::OP_WRITE: begin
                    slot_reg <= (slot_reg == SLOT_LAST) ? '0 : slot_reg + 1'b1;
                    seen_reg <= seen_new;
                    k_reg    <= '0;
                end
                cci_pkg::OP_ACC1, cci_pkg::OP_ACC2: begin
                    k_reg <= sts.last_entry ? '0 : k_reg + 1'b1;
                end
                cci_pkg::OP_NUM:    qcnt_reg <= '0;
                cci_pkg::OP_Q_STEP: qcnt_reg <= qcnt_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            cci_pkg::OP_LOAD: begin
                tpq_reg  <= cci_pkg::SUM3_W'(high_price) + cci_pkg::SUM3_W'(low_price)
                          + cci_pkg::SUM3_W'(close_price);
            end
            cci_pkg::OP_TP_STEP: begin
                if (tcnt_reg == '0) begin
                    tacc_reg <= TACC_W'(t_prod);
                end else begin
                    tacc_reg <= tacc_reg + {t_prod, HALF'(0)};
                end
            end
            cci_pkg::OP_WRITE: begin
                cur_reg  <= slot_reg;
                addr_reg <= slot_reg;
                w_reg    <= (p_clamp < seen_new) ? p_clamp : seen_new;
                sum_reg  <= '0;
                dev_reg  <= '0;
            end
            cci_pkg::OP_ACC1: begin
                sum_reg  <= sum_reg + SW'(rdata_reg);
                addr_reg <= sts.last_entry ? cur_reg : addr_dec;
            end
            cci_pkg::OP_MUL2: prod_reg <= SW'(w_reg) * SW'(rdata_reg);
            cci_pkg::OP_ACC2: begin
                dev_reg  <= dev_reg + DW'(absdiff);
                addr_reg <= addr_dec;
            end
            cci_pkg::OP_PROD_TP: prod_reg <= SW'(w_reg) * SW'(tp_val);
            cci_pkg::OP_MAG: begin
                neg_reg <= prod_reg < sum_reg;
                mag_reg <= absdiff;
            end
            cci_pkg::OP_NUMW: nw_reg <= DW'(w_reg) * DW'(mag_reg);
            cci_pkg::OP_NUM: begin
                // times 51200 = 2^15 + 2^14 + 2^11
                qsh_reg  <= (num_base << 15) + (num_base << 14) + (num_base << 11);
                den_reg  <= RW'(dev_reg) + (RW'(dev_reg) << 1);
                qrem_reg <= '0;
            end
            cci_pkg::OP_Q_STEP: begin
                if (q_trial >= den_reg) begin
                    qrem_reg <= q_trial - den_reg;
                    qsh_reg  <= {qsh_reg[NW-2:0], 1'b1};
                end else begin
                    qrem_reg <= q_trial;
                    qsh_reg  <= {qsh_reg[NW-2:0], 1'b0};
                end
            end
            cci_pkg::OP_OUT: begin
                if (dev_reg == '0) begin
                    cci_reg  <= '0;
                    flat_reg <= 1'b1;
                    sat_reg  <= 1'b0;
                end else if (neg_reg) begin
                    flat_reg <= 1'b0;
                    if (qsh_reg > NW'(cci_pkg::CCI_MIN)) begin
                        cci_reg <= cci_pkg::CCI_MIN;
                        sat_reg <= 1'b1;
                    end else begin
                        cci_reg <= -qsh_reg[cci_pkg::CCI_W-1:0];
                        sat_reg <= 1'b0;
                    end
                end else begin
                    flat_reg <= 1'b0;
                    if (qsh_reg > NW'(cci_pkg::CCI_MAX)) begin
                        cci_reg <= cci_pkg::CCI_MAX;
                        sat_reg <= 1'b1;
                    end else begin
                        cci_reg <= qsh_reg[cci_pkg::CCI_W-1:0];
                        sat_reg <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign sts.tp_done    = (tcnt_reg == cci_pkg::TP_STEPS);
    assign sts.last_entry = (k_reg == w_reg - 1'b1);
    assign sts.q_done     = (qcnt_reg == QCW'(NW));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign cci_value   = cci_reg;
    assign flat_window = flat_reg;
    assign saturated   = sat_reg;

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for the commodity channel index block.
module tb_top;

    localparam int RING_DEPTH = 64;

    typedef struct packed {
        logic [23:0] value;
        logic        flat;
        logic        sat;
    } cci_word_t;

    // Tracks series history and the queue of index words still owed.
    class cci_scoreboard;
        logic [31:0] tp_hist [RING_DEPTH];
        int unsigned next_slot;
        int unsigned seen_cnt;
        int unsigned period;
        cci_word_t   owed [$];
        int          errors;

        function void clear();
            next_slot = 0;
            seen_cnt  = 0;
            period    = 20;
            owed.delete();
            errors    = 0;
        endfunction

        function void note_bar(logic [31:0] hi, logic [31:0] lo, logic [31:0] cl,
                               logic restart);
            logic [33:0]  sum3;
            logic [31:0]  tp;
            int unsigned  cur, p, w, k;
            logic [63:0]  s, d, wtp, mag, q;
            logic [127:0] num;
            logic         neg;
            cci_word_t    r;
            if (restart) begin
                next_slot = 0;
                seen_cnt  = 0;
            end
            sum3 = {2'b0, hi} + {2'b0, lo} + {2'b0, cl};
            tp = 32'(sum3 / 3);
            cur = next_slot;
            tp_hist[cur] = tp;
            next_slot = (cur + 1) % RING_DEPTH;
            if (seen_cnt < RING_DEPTH) seen_cnt++;
            p = (period < 1) ? 1 : (period > RING_DEPTH ? RING_DEPTH : period);
            w = (p < seen_cnt) ? p : seen_cnt;
            s = 0;
            d = 0;
            for (k = 0; k < w; k++) s += tp_hist[(cur + RING_DEPTH - k) % RING_DEPTH];
            for (k = 0; k < w; k++) begin
                wtp = 64'(w) * tp_hist[(cur + RING_DEPTH - k) % RING_DEPTH];
                d += (wtp >= s) ? wtp - s : s - wtp;
            end
            wtp = 64'(w) * tp;
            neg = wtp < s;
            mag = neg ? s - wtp : wtp - s;
            r = '0;
            if (d == 0) begin
                r.flat = 1'b1;
            end else begin
                num = 128'(w) * 128'(mag) * 128'd51200;
                q = 64'(num / (128'(d) * 3));
                if (neg) begin
                    if (q > 64'd8388608) begin
                        r.value = cci_pkg::CCI_MIN;
                        r.sat = 1'b1;
                    end else begin
                        r.value = 24'(-q);
                    end
                end else if (q > 64'd8388607) begin
                    r.value = cci_pkg::CCI_MAX;
                    r.sat = 1'b1;
                end else begin
                    r.value = q[23:0];
                end
            end
            owed.push_back(r);
        endfunction

        function void check_word(cci_word_t got);
            cci_word_t exp_w;
            if (owed.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word: %h", got);
                return;
            end
            exp_w = owed.pop_front();
            if (got !== exp_w) begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: exp value %h flat %b sat %b, got %h %b %b",
                             exp_w.value, exp_w.flat, exp_w.sat,
                             got.value, got.flat, got.sat);
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    cci_scoreboard scb = new();
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;

    commodity_channel_index i_dut (.*);

    always #4 aclk = ~aclk;

    // Output side: random stall, long hold-offs on request.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) scb.check_word({m_tdata, m_tuser[0], m_tuser[1]});
            if (hold_cycles > 0) begin
                hold_cycles <= hold_cycles - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic apb_write(logic [2:0] addr, logic [31:0] data);
        @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        penable <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        scb.period = data[6:0];
    endtask

    // valid stays up after an accept until the next word or an idle gap
    task automatic send_bar(logic [31:0] hi, logic [31:0] lo, logic [31:0] cl,
                            logic restart);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {cl, lo, hi};
        s_tuser <= restart;
        do @(posedge aclk); while (!s_tready);
        scb.note_bar(hi, lo, cl, restart);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (scb.owed.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_price(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'h0064_0000 + $urandom_range(32'h0008_0000);
            2: return $urandom_range(3);
            default: return 32'hFFFF_FFFF - $urandom_range(7);
        endcase
    endfunction

    task automatic random_bars(int n);
        logic [31:0] base;
        int mode;
        for (int i = 0; i < n; i++) begin
            mode = $urandom_range(9);
            if (mode < 6) begin
                base = rand_price(1);
                send_bar(base + $urandom_range(32'h4_0000), base - $urandom_range(32'h4_0000),
                         base + $urandom_range(32'h2_0000) - 32'h1_0000,
                         $urandom_range(60) == 0);
            end else begin
                mode = $urandom_range(3);
                send_bar(rand_price(mode), rand_price(mode), rand_price(mode),
                         $urandom_range(20) == 0);
            end
        end
    endtask

    initial begin
        scb.clear();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, flat windows, restart, one-bar window
        send_bar('0, '0, '0, 1'b1);
        send_bar('1, '1, '1, 1'b0);
        send_bar('0, '0, '0, 1'b0);
        send_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0003, 1'b0);
        send_bar(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0);
        send_bar('1, 32'h0, 32'h8000_0000, 1'b1);
        send_bar(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF, 1'b0);
        for (int i = 0; i < 6; i++) send_bar(32'd100, 32'd100, 32'd100, 1'b0);
        send_bar(32'd103, 32'd100, 32'd100, 1'b0);
        send_bar(32'd0, 32'd0, 32'd0, 1'b0);
        drain();
        apb_write(cci_pkg::REG_PERIOD_ADDR, 32'd1);
        send_bar('1, '0, '1, 1'b1);
        send_bar(32'd7, 32'd8, 32'd9, 1'b0);
        drain();
        apb_write(cci_pkg::REG_PERIOD_ADDR, 32'd0);
        send_bar(32'd7, 32'd8, 32'd9, 1'b0);
        drain();
        apb_write(cci_pkg::REG_PERIOD_ADDR, 32'd127);
        send_bar(32'd70, 32'd8, 32'd9, 1'b0);
        drain();

        // random phases over periods and idling mixes
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            case (ph)
                0: apb_write(cci_pkg::REG_PERIOD_ADDR, 32'd64);
                1: apb_write(cci_pkg::REG_PERIOD_ADDR, 32'd2);
                2: apb_write(cci_pkg::REG_PERIOD_ADDR, 32'd20);
                3: apb_write(cci_pkg::REG_PERIOD_ADDR, 32'd1);
                default: apb_write(cci_pkg::REG_PERIOD_ADDR, $urandom_range(1, 64));
            endcase
            if (ph == 2) hold_cycles = 3000;
            random_bars(ph < 2 ? 150 : 270);
            drain();
        end

        if (scb.errors == 0 && scb.owed.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("Test completed with failures");
        $finish;
    end
endmodule
